### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked on clk and quiet during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define CHECK_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/pidtz_pkg.sv
// ----------------------------------------------------------------------------
// pidtz_pkg
// types and constants of the pid turn controller with integral zone
// ----------------------------------------------------------------------------
package pidtz_pkg;

    localparam int GAIN_FRACTION_BITS = 8;
    localparam int BRAKE_LEVEL        = 10;
    localparam int POWER_LIMIT        = 127;

    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 3;
    localparam int ERR_W       = 18;
    localparam int DIFF_W      = ERR_W + 1;
    localparam int SUM_W       = 32;
    localparam int TICK_W      = 16;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_TARGET_HEADING = 3'd0,
        REG_TURN_DIRECTION = 3'd1,
        REG_GAIN_P         = 3'd2,
        REG_GAIN_I         = 3'd3,
        REG_GAIN_D         = 3'd4,
        REG_INTEGRAL_ZONE  = 3'd5,
        REG_TIMEOUT_TICKS  = 3'd6,
        REG_ABSOLUTE_MODE  = 3'd7
    } cfg_reg_t;

    typedef enum logic [1:0] {
        KIND_START = 2'd0,
        KIND_BRAKE = 2'd1,
        KIND_PID   = 2'd2
    } item_kind_t;

    typedef struct packed {
        logic               action;
        logic signed [15:0] heading;
    } sample_t;

    typedef struct packed {
        logic signed [7:0] left_power;
        logic signed [7:0] right_power;
        logic              finished;
    } result_t;

endpackage

### rtl/pid_turn_with_integral_zone_unit.sv
// ----------------------------------------------------------------------------
// pid_turn_with_integral_zone_unit
// pid turn controller with integral zone, one heading sample per transaction
// ----------------------------------------------------------------------------
// pipeline: error, integral and tick state update in the acceptance cycle,
//   then a product stage and a scale/saturate stage fill the result register
// throughput: one sample per cycle unless a held result backs the pipeline up
// reset: asynchronous active low; registers to their defaults (direction 1,
//   absolute mode on, rest zero), pid state cleared, pipeline empty
`include "assert_macros.svh"

module pid_turn_with_integral_zone_unit (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        cfg_wr_en,
    input  logic [pidtz_pkg::CFG_INDEX_W-1:0]           cfg_index,
    input  logic [pidtz_pkg::CFG_DATA_W-1:0]            cfg_data,
    input  logic                                        sample_valid,
    output logic                                        sample_ready,
    input  pidtz_pkg::sample_t                          sample,
    output logic                                        result_valid,
    input  logic                                        result_ready,
    output pidtz_pkg::result_t                          result
);
    import pidtz_pkg::*;

    localparam int PROD_P_W = ERR_W + 17;
    localparam int PROD_D_W = DIFF_W + 17;
    localparam int PROD_I_W = SUM_W + 17;
    localparam int ACC_W    = PROD_I_W + 2;

    // configuration registers
    logic signed [15:0] target_heading_reg;
    logic signed [1:0]  turn_direction_reg;
    logic [15:0]        gain_p_reg;
    logic [15:0]        gain_i_reg;
    logic [15:0]        gain_d_reg;
    logic [15:0]        integral_zone_reg;
    logic [15:0]        timeout_ticks_reg;
    logic               absolute_mode_reg;

    // pid state
    logic signed [ERR_W-1:0] prev_error_reg, prev_error_next;
    logic signed [SUM_W-1:0] integ_sum_reg, integ_sum_next;
    logic [TICK_W-1:0]       tick_count_reg, tick_count_next;

    // pipeline
    logic                     s1_valid_reg, s1_valid_next;
    item_kind_t               s1_kind_reg, s1_kind_next;
    logic signed [ERR_W-1:0]  s1_err_reg;
    logic signed [DIFF_W-1:0] s1_diff_reg;
    logic signed [SUM_W-1:0]  s1_sum_reg;

    logic                       s2_valid_reg, s2_valid_next;
    item_kind_t                 s2_kind_reg;
    logic signed [PROD_P_W-1:0] s2_prod_p_reg;
    logic signed [PROD_I_W-1:0] s2_prod_i_reg;
    logic signed [PROD_D_W-1:0] s2_prod_d_reg;

    logic    result_valid_reg, result_valid_next;
    result_t result_reg, result_next;

    logic en_out, en_s2, en_s1, accept;

    // stage 1 datapath
    logic signed [16:0]       head_ext, head_sel;
    logic signed [ERR_W-1:0]  err, abs_err;
    logic signed [DIFF_W-1:0] diff;
    logic signed [SUM_W:0]    sum_wide;
    logic signed [SUM_W-1:0]  sum_sat;
    logic                     in_zone, brake;

    // stage 3 datapath
    logic signed [ACC_W-1:0] acc;
    logic [ACC_W-1:0]        acc_mag, acc_shift;
    logic [6:0]              mag_sat;
    logic signed [7:0]       mag_sgn, brake_pos;
    logic signed [1:0]       dir;

    // ---------------------------------------------------------------- config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_heading_reg <= '0;
            turn_direction_reg <= 2'sd1;
            gain_p_reg         <= '0;
            gain_i_reg         <= '0;
            gain_d_reg         <= '0;
            integral_zone_reg  <= '0;
            timeout_ticks_reg  <= '0;
            absolute_mode_reg  <= 1'b1;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_TARGET_HEADING: target_heading_reg <= $signed(cfg_data);
                REG_TURN_DIRECTION: turn_direction_reg <= $signed(cfg_data[1:0]);
                REG_GAIN_P:         gain_p_reg         <= cfg_data;
                REG_GAIN_I:         gain_i_reg         <= cfg_data;
                REG_GAIN_D:         gain_d_reg         <= cfg_data;
                REG_INTEGRAL_ZONE:  integral_zone_reg  <= cfg_data;
                REG_TIMEOUT_TICKS:  timeout_ticks_reg  <= cfg_data;
                REG_ABSOLUTE_MODE:  absolute_mode_reg  <= cfg_data[0];
            endcase
        end
    end

    // ---------------------------------------------------------------- flow
    assign en_out       = !result_valid_reg || result_ready;
    assign en_s2        = !s2_valid_reg || en_out;
    assign en_s1        = !s1_valid_reg || en_s2;
    assign sample_ready = en_s1;
    assign accept       = sample_valid && en_s1;

    // ---------------------------------------------------------------- stage 1
    always_comb
    begin
        head_ext = {sample.heading[15], sample.heading};
        head_sel = (absolute_mode_reg && head_ext[16]) ? -head_ext : head_ext;
        err      = {{2{target_heading_reg[15]}}, target_heading_reg}
                 - {head_sel[16], head_sel};
        // one bit wider, the error can swing across the full range
        diff     = {err[ERR_W-1], err} - {prev_error_reg[ERR_W-1], prev_error_reg};
        abs_err  = err[ERR_W-1] ? -err : err;
        in_zone  = abs_err[16:0] < {1'b0, integral_zone_reg};
        sum_wide = {integ_sum_reg[SUM_W-1], integ_sum_reg}
                 + {{(SUM_W+1-ERR_W){err[ERR_W-1]}}, err};
        // clamp to the signed 32 bit range
        if (sum_wide[SUM_W] != sum_wide[SUM_W-1])
            sum_sat = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                      : {1'b0, {(SUM_W-1){1'b1}}};
        else
            sum_sat = sum_wide[SUM_W-1:0];
        brake = tick_count_reg >= timeout_ticks_reg;

        prev_error_next = prev_error_reg;
        integ_sum_next  = integ_sum_reg;
        tick_count_next = tick_count_reg;
        s1_kind_next    = s1_kind_reg;
        if (accept)
        begin
            priority if (!sample.action)
            begin
                prev_error_next = '0;
                integ_sum_next  = '0;
                tick_count_next = '0;
                s1_kind_next    = KIND_START;
            end
            else if (brake)
            begin
                s1_kind_next = KIND_BRAKE;
            end
            else
            begin
                prev_error_next = err;
                integ_sum_next  = in_zone ? sum_sat : '0;
                tick_count_next = tick_count_reg + TICK_W'(1);
                s1_kind_next    = KIND_PID;
            end
        end
        s1_valid_next = en_s1 ? accept : s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_error_reg <= '0;
            integ_sum_reg  <= '0;
            tick_count_reg <= '0;
            s1_valid_reg   <= 1'b0;
            s1_kind_reg    <= KIND_START;
        end
        else
        begin
            prev_error_reg <= prev_error_next;
            integ_sum_reg  <= integ_sum_next;
            tick_count_reg <= tick_count_next;
            s1_valid_reg   <= s1_valid_next;
            s1_kind_reg    <= s1_kind_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_err_reg  <= err;
            s1_diff_reg <= diff;
            s1_sum_reg  <= integ_sum_next;
        end
    end

    // ---------------------------------------------------------------- stage 2
    assign s2_valid_next = en_s2 ? s1_valid_reg : s2_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else
            s2_valid_reg <= s2_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (en_s2 && s1_valid_reg)
        begin
            s2_kind_reg   <= s1_kind_reg;
            s2_prod_p_reg <= $signed({1'b0, gain_p_reg}) * s1_err_reg;
            s2_prod_i_reg <= $signed({1'b0, gain_i_reg}) * s1_sum_reg;
            s2_prod_d_reg <= $signed({1'b0, gain_d_reg}) * s1_diff_reg;
        end
    end

    // ---------------------------------------------------------------- stage 3
    always_comb
    begin
        acc = {{(ACC_W-PROD_P_W){s2_prod_p_reg[PROD_P_W-1]}}, s2_prod_p_reg}
            + {{(ACC_W-PROD_I_W){s2_prod_i_reg[PROD_I_W-1]}}, s2_prod_i_reg}
            + {{(ACC_W-PROD_D_W){s2_prod_d_reg[PROD_D_W-1]}}, s2_prod_d_reg};
        // truncate toward zero by shifting the magnitude
        acc_mag   = acc[ACC_W-1] ? $unsigned(-acc) : $unsigned(acc);
        acc_shift = acc_mag >> GAIN_FRACTION_BITS;
        mag_sat   = (acc_shift > ACC_W'(POWER_LIMIT)) ? 7'(POWER_LIMIT) : acc_shift[6:0];
        // sign of the sum comes back after clipping
        mag_sgn   = acc[ACC_W-1] ? -$signed({1'b0, mag_sat}) : $signed({1'b0, mag_sat});
        brake_pos = 8'(BRAKE_LEVEL);
        // direction pattern -2 acts as -1
        dir = (turn_direction_reg == 2'sb10) ? 2'sb11 : turn_direction_reg;

        result_next = result_reg;
        if (en_out && s2_valid_reg)
        begin
            unique case (s2_kind_reg)
                KIND_START:
                begin
                    result_next.left_power  = '0;
                    result_next.right_power = '0;
                    result_next.finished    = 1'b0;
                end
                KIND_BRAKE:
                begin
                    result_next.finished = 1'b1;
                    unique case (dir)
                        2'sb01:
                        begin
                            result_next.left_power  = -brake_pos;
                            result_next.right_power = brake_pos;
                        end
                        2'sb11:
                        begin
                            result_next.left_power  = brake_pos;
                            result_next.right_power = -brake_pos;
                        end
                        default:
                        begin
                            result_next.left_power  = '0;
                            result_next.right_power = '0;
                        end
                    endcase
                end
                default:
                begin
                    result_next.finished = 1'b0;
                    unique case (dir)
                        2'sb01:
                        begin
                            result_next.left_power  = mag_sgn;
                            result_next.right_power = -mag_sgn;
                        end
                        2'sb11:
                        begin
                            result_next.left_power  = -mag_sgn;
                            result_next.right_power = mag_sgn;
                        end
                        default:
                        begin
                            result_next.left_power  = '0;
                            result_next.right_power = '0;
                        end
                    endcase
                end
            endcase
        end
        result_valid_next = en_out ? s2_valid_reg : result_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else
            result_valid_reg <= result_valid_next;
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // ---------------------------------------------------------------- checks
    `CHECK_SAME(a_ready_when_out_empty, !result_valid_reg, sample_ready,
        "input stalled with an empty output register")
    `CHECK_NEXT(a_start_clears_state, accept && !sample.action,
        tick_count_reg == '0 && integ_sum_reg == '0 && prev_error_reg == '0,
        "start transaction did not clear the pid state")
    `CHECK_SAME(a_power_in_range, result_valid,
        result.left_power != 8'sh80 && result.right_power != 8'sh80,
        "drive power outside the saturation range")
    `CHECK_SAME(a_sides_opposite, result_valid,
        result.left_power == -result.right_power,
        "left and right power are not opposite")

endmodule

### tb/pid_turn_with_integral_zone_unit_test.sv
// ----------------------------------------------------------------------------
// pid_turn_with_integral_zone_unit_test
// self-checking bench for the pid turn controller: a queued sample driver and
// a result monitor around the block; every accepted sample is run through an
// in-bench controller model and each result is matched in order against it
// ----------------------------------------------------------------------------
module pid_turn_with_integral_zone_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    import pidtz_pkg::*;

    localparam logic ACT_START  = 1'b0;
    localparam logic ACT_SAMPLE = 1'b1;

    localparam logic [15:0] DIR_NONE    = 16'd0;
    localparam logic [15:0] DIR_POS     = 16'd1;
    localparam logic [15:0] DIR_ALT_NEG = 16'd2;
    localparam logic [15:0] DIR_NEG     = 16'd3;

    localparam int PIPE_LATENCY    = 3;
    localparam int DRAIN_CYCLES    = 4 * PIPE_LATENCY;
    localparam int HOLD_CYCLES     = 200;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int SOAK_SAMPLES    = 16;
    localparam int RANDOM_PHASES   = 10;
    localparam int ITEMS_PER_PHASE = 50;

    localparam longint SUM_MAX = 64'sd2147483647;
    localparam longint SUM_MIN = -64'sd2147483648;

    logic                   clk;
    logic                   rst_n        = 1'b0;
    logic                   cfg_wr_en    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index    = '0;
    logic [CFG_DATA_W-1:0]  cfg_data     = '0;
    logic                   sample_valid = 1'b0;
    logic                   sample_ready;
    sample_t                sample       = '0;
    logic                   result_valid;
    logic                   result_ready = 1'b0;
    result_t                result;

    pid_turn_with_integral_zone_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // controller model: configuration copy
    longint            tgt_heading = 0;
    logic signed [1:0] turn_dir    = 2'sb01;
    longint            kp          = 0;
    longint            ki          = 0;
    longint            kd          = 0;
    longint            zone_limit  = 0;
    logic [15:0]       timeout_lim = '0;
    logic              abs_mode    = 1'b1;

    // controller model: turn state
    longint      prev_error = 0;
    longint      integ_sum  = 0;
    logic [15:0] turn_ticks = '0;

    sample_t sample_backlog[$];
    result_t expected_power[$];

    logic sample_taken = 1'b0;
    logic calm         = 1'b0;
    logic hold_armed   = 1'b0;
    logic hold_done    = 1'b0;
    int   hold_left    = 0;
    int   stall_cycles = 0;
    int   mismatches   = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic result_t compute_turn_power(sample_t s);
        result_t r;
        longint  dir;
        longint  h;
        longint  err;
        longint  diff;
        longint  acc;
        longint  mag;
        longint  pwr;
        longint  neg_pwr;
        r = '0;
        dir = longint'(turn_dir);
        if (dir < -1)
            dir = -1;
        if (s.action == ACT_START)
        begin
            prev_error = 0;
            integ_sum  = 0;
            turn_ticks = '0;
            return r;
        end
        // brake once the turn has used up its samples, state untouched
        if (turn_ticks >= timeout_lim)
        begin
            pwr = dir * BRAKE_LEVEL;
            neg_pwr = -pwr;
            r.left_power  = neg_pwr[7:0];
            r.right_power = pwr[7:0];
            r.finished    = 1'b1;
            return r;
        end
        h = longint'($signed(s.heading));
        if (abs_mode && h < 0)
            h = -h;
        err = tgt_heading - h;
        diff = err - prev_error;
        prev_error = err;
        if ((err < 0 ? -err : err) < zone_limit)
        begin
            integ_sum = integ_sum + err;
            if (integ_sum > SUM_MAX)
                integ_sum = SUM_MAX;
            if (integ_sum < SUM_MIN)
                integ_sum = SUM_MIN;
        end
        else
            integ_sum = 0;
        acc = kp * err + ki * integ_sum + kd * diff;
        // truncate toward zero, then clip
        mag = (acc < 0 ? -acc : acc) >> GAIN_FRACTION_BITS;
        if (mag > POWER_LIMIT)
            mag = POWER_LIMIT;
        if (acc < 0)
            mag = -mag;
        pwr = dir * mag;
        neg_pwr = -pwr;
        turn_ticks = turn_ticks + 16'd1;
        r.left_power  = pwr[7:0];
        r.right_power = neg_pwr[7:0];
        return r;
    endfunction

    // sample driver
    always @(negedge clk)
    begin
        if (!sample_valid || sample_taken)
        begin
            if (rst_n && sample_backlog.size() != 0 && (calm || $urandom_range(0, 99) >= 10))
            begin
                sample       <= sample_backlog.pop_front();
                sample_valid <= 1'b1;
            end
            else
                sample_valid <= 1'b0;
        end
    end

    // result receiver, with one long hold-off so the pipeline backs up
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            if (hold_left == 0)
                hold_done = 1'b1;
            result_ready <= 1'b0;
        end
        else if (hold_armed && !hold_done)
        begin
            hold_left = HOLD_CYCLES;
            result_ready <= 1'b0;
        end
        else
            result_ready <= rst_n && (calm || $urandom_range(0, 99) >= 10);
    end

    // monitor: predicts on sample transactions, checks result transactions
    always @(posedge clk)
    begin : monitor
        result_t want;
        logic    in_xfer;
        logic    out_xfer;
        in_xfer  = rst_n && sample_valid && sample_ready;
        out_xfer = rst_n && result_valid && result_ready;
        sample_taken <= in_xfer;
        if (in_xfer)
            expected_power.push_back(compute_turn_power(sample));
        if (out_xfer)
        begin
            if (expected_power.size() == 0)
            begin
                $error("result transaction with no sample outstanding");
                mismatches = mismatches + 1;
            end
            else
            begin
                want = expected_power.pop_front();
                if (result.left_power !== want.left_power)
                begin
                    $error("left_power: expected %0d, got %0d", want.left_power,
                           result.left_power);
                    mismatches = mismatches + 1;
                end
                if (result.right_power !== want.right_power)
                begin
                    $error("right_power: expected %0d, got %0d", want.right_power,
                           result.right_power);
                    mismatches = mismatches + 1;
                end
                if (result.finished !== want.finished)
                begin
                    $error("finished: expected %0d, got %0d", want.finished,
                           result.finished);
                    mismatches = mismatches + 1;
                end
            end
        end
        if (!rst_n || in_xfer || out_xfer)
            stall_cycles = 0;
        else
            stall_cycles = stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic queue_item(logic action, logic [15:0] heading);
        sample_t s;
        s.action  = action;
        s.heading = heading;
        sample_backlog.push_back(s);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [15:0] value);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_TARGET_HEADING: tgt_heading = longint'($signed(value));
            REG_TURN_DIRECTION: turn_dir    = value[1:0];
            REG_GAIN_P:         kp          = longint'(value);
            REG_GAIN_I:         ki          = longint'(value);
            REG_GAIN_D:         kd          = longint'(value);
            REG_INTEGRAL_ZONE:  zone_limit  = longint'(value);
            REG_TIMEOUT_TICKS:  timeout_lim = value;
            REG_ABSOLUTE_MODE:  abs_mode    = value[0];
            default: ;
        endcase
    endtask

    task automatic configure(logic [15:0] target, logic [15:0] dir, logic [15:0] kp_v,
                             logic [15:0] ki_v, logic [15:0] kd_v, logic [15:0] zone_v,
                             logic [15:0] timeout_v, logic [15:0] abs_v);
        write_reg(REG_TARGET_HEADING, target);
        write_reg(REG_TURN_DIRECTION, dir);
        write_reg(REG_GAIN_P, kp_v);
        write_reg(REG_GAIN_I, ki_v);
        write_reg(REG_GAIN_D, kd_v);
        write_reg(REG_INTEGRAL_ZONE, zone_v);
        write_reg(REG_TIMEOUT_TICKS, timeout_v);
        write_reg(REG_ABSOLUTE_MODE, abs_v);
    endtask

    // everything sent has come back and the pipeline has emptied
    task automatic wait_idle();
        do
            @(posedge clk);
        while (sample_backlog.size() != 0 || sample_valid || expected_power.size() != 0);
        repeat (PIPE_LATENCY) @(posedge clk);
    endtask

    function automatic logic [15:0] pick_gain();
        case ($urandom_range(0, 4))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return 16'($urandom);
            default: return 16'($urandom_range(0, 1023));
        endcase
    endfunction

    initial
    begin
        longint      near;
        logic [15:0] zone_v;
        logic [15:0] timeout_v;
        logic [15:0] target_v;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // defaults: zero timeout brakes on the first sample
        queue_item(ACT_SAMPLE, 16'd0);
        queue_item(ACT_START, 16'h5A5A);
        queue_item(ACT_SAMPLE, 16'h8000);
        wait_idle();

        // absolute heading, integral zone, timeout reached after eight samples
        configure(16'd1000, DIR_POS, 16'd256, 16'd64, 16'd128, 16'd500, 16'd8, 16'd1);
        queue_item(ACT_START, 16'd0);
        queue_item(ACT_SAMPLE, 16'h8000);
        queue_item(ACT_SAMPLE, 16'h7FFF);
        queue_item(ACT_SAMPLE, 16'd0);
        queue_item(ACT_SAMPLE, 16'd900);
        queue_item(ACT_SAMPLE, 16'd990);
        queue_item(ACT_SAMPLE, 16'd1010);
        queue_item(ACT_SAMPLE, 16'd1000);
        queue_item(ACT_SAMPLE, 16'd995);
        queue_item(ACT_SAMPLE, 16'd995);
        queue_item(ACT_SAMPLE, 16'hFFFF);
        wait_idle();

        // signed heading, full gains, direction pattern that reads as -1
        configure(16'h8000, DIR_ALT_NEG, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                  16'hFFFF, 16'd0);
        queue_item(ACT_START, 16'd0);
        queue_item(ACT_SAMPLE, 16'h7FFF);
        queue_item(ACT_SAMPLE, 16'h8000);
        queue_item(ACT_SAMPLE, 16'h7FFE);
        queue_item(ACT_SAMPLE, 16'hFFFF);
        queue_item(ACT_SAMPLE, 16'd0);
        wait_idle();

        // no direction gives zero power, also when braking
        configure(16'h7FFF, DIR_NONE, 16'd300, 16'd10, 16'd300, 16'd300, 16'd1, 16'd1);
        queue_item(ACT_START, 16'd0);
        queue_item(ACT_SAMPLE, 16'd100);
        queue_item(ACT_SAMPLE, 16'd100);
        wait_idle();
        write_reg(REG_TURN_DIRECTION, DIR_NEG);
        queue_item(ACT_SAMPLE, 16'd100);
        wait_idle();

        // integral build-up: run of large positive errors
        configure(16'h7FFF, DIR_POS, 16'd0, 16'd1, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0);
        queue_item(ACT_START, 16'd0);
        for (int n = 0; n < SOAK_SAMPLES; n++)
            queue_item(ACT_SAMPLE, 16'h8001);
        wait_idle();
        // proportional term against the built-up sum
        write_reg(REG_TARGET_HEADING, 16'd0);
        write_reg(REG_GAIN_P, 16'hFFFF);
        repeat (4) queue_item(ACT_SAMPLE, 16'h7FFF);
        wait_idle();

        // and towards the bottom
        configure(16'h8000, DIR_POS, 16'd0, 16'd1, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0);
        queue_item(ACT_START, 16'd0);
        for (int n = 0; n < SOAK_SAMPLES; n++)
            queue_item(ACT_SAMPLE, 16'h7FFE);
        wait_idle();
        write_reg(REG_TARGET_HEADING, 16'd0);
        write_reg(REG_GAIN_P, 16'hFFFF);
        repeat (3) queue_item(ACT_SAMPLE, 16'h8000);
        wait_idle();

        // random turns
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            calm = (phase == 4);
            if (phase == 2)
                hold_armed = 1'b1;
            case ($urandom_range(0, 3))
                0:       target_v = 16'($urandom);
                1:       target_v = ($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000;
                default: target_v = 16'($urandom_range(0, 4000) - 2000);
            endcase
            case ($urandom_range(0, 3))
                0:       zone_v = 16'd0;
                1:       zone_v = 16'hFFFF;
                2:       zone_v = 16'($urandom);
                default: zone_v = 16'($urandom_range(0, 3000));
            endcase
            case ($urandom_range(0, 4))
                0:       timeout_v = 16'd0;
                1:       timeout_v = 16'hFFFF;
                2:       timeout_v = 16'($urandom);
                default: timeout_v = 16'($urandom_range(1, 60));
            endcase
            configure(target_v, 16'($urandom), pick_gain(), pick_gain(), pick_gain(),
                      zone_v, timeout_v, 16'($urandom));
            // now and then carry the previous turn's state over
            if ($urandom_range(0, 9) != 0)
                queue_item(ACT_START, 16'($urandom));
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                near = tgt_heading + longint'($urandom_range(0, 600)) - 300;
                if ($urandom_range(0, 99) < 6)
                    queue_item(ACT_START, 16'($urandom));
                else
                    case ($urandom_range(0, 3))
                        0, 1: queue_item(ACT_SAMPLE, near[15:0]);
                        2:    queue_item(ACT_SAMPLE, 16'($urandom));
                        default:
                        begin
                            near = -near;
                            queue_item(ACT_SAMPLE, near[15:0]);
                        end
                    endcase
            end
            wait_idle();
        end
        calm = 1'b0;

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_power.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
